// ===== design/bitmap_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// bitmap block allocator assertion macros
// shared concurrent assertion helpers for the checker
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// clocked assertion with an explicit clock and active-low reset
`define BBA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion on the default clock and reset names
`define BBA_ASSERT(lbl, prop, msg) \
    `BBA_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// types, constants and control structs of the bitmap block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

    // geometry of the allocation bitmap
    localparam int NUM_BLOCKS = 65536;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = NUM_BLOCKS / WORD_BITS;
    localparam int WORD_W     = $clog2(NUM_WORDS);
    localparam int OFS_W      = $clog2(WORD_BITS);
    localparam int LANE_BITS  = 8;
    localparam int LANE_W     = $clog2(WORD_BITS / LANE_BITS);
    localparam int LANE_OFS_W = $clog2(LANE_BITS);
    localparam int BLK_W      = 16;
    localparam int CNT_W      = 17;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    // request kinds
    typedef enum logic [1:0] {
        REQ_FIND  = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_FREE  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_PAST   = 2'd1,
        ST_USED   = 2'd2,
        ST_NOFREE = 2'd3
    } t_status;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FIND_RD,
        S_FIND_LANE,
        S_CHK_RD,
        S_CHK_TEST,
        S_SET_RD,
        S_SET_WR,
        S_RESP
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic    req_load;
        logic    clr_write;
        logic    scan_init;
        logic    mem_read;
        logic    lane_step;
        logic    word_next;
        logic    status_load;
        t_status status_val;
        logic    map_write;
        logic    cnt_update;
        logic    out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_req kind;
        logic count_zero;
        logic range_past;
        logic clr_last;
        logic lane_found;
        logic lane_end;
        logic lane_last;
        logic word_hit;
        logic last_word;
        logic out_free;
    } t_sts;

endpackage

// ===== design/bba_if.sv =====
// ----------------------------------------------------------------------------
// bba interfaces
// request, response and configuration channels with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bba_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [bba_pkg::BLK_W-1:0]     range_start;
    logic [bba_pkg::BLK_W-1:0]     block_count;
    modport source (output valid, req_type, range_start, block_count, input ready);
    modport sink   (input valid, req_type, range_start, block_count, output ready);
endinterface

interface bba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [bba_pkg::BLK_W-1:0]     found_start;
    logic [bba_pkg::CNT_W-1:0]     free_blocks;
    modport source (output valid, status, found_start, free_blocks, input ready);
    modport sink   (input valid, status, found_start, free_blocks, output ready);
endinterface

interface bba_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bba_pkg::CNT_W-1:0]     usable_blocks;
    modport source (output valid, usable_blocks, input ready);
    modport sink   (input valid, usable_blocks, output ready);
endinterface

// ===== design/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bba_datapath.sv =====
// ----------------------------------------------------------------------------
// bba_datapath
// bitmap memory, run scanner, range masks, free counter and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bba_pkg::t_cmd                 i_cmd,
    output bba_pkg::t_sts                 o_sts,
    input  logic [1:0]                    i_req_type,
    input  logic [bba_pkg::BLK_W-1:0]     i_range_start,
    input  logic [bba_pkg::BLK_W-1:0]     i_block_count,
    input  logic                          i_cfg_we,
    input  logic [bba_pkg::CNT_W-1:0]     i_cfg_total,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [1:0]                    o_status,
    output logic [bba_pkg::BLK_W-1:0]     o_found,
    output logic [bba_pkg::CNT_W-1:0]     o_free
);

    localparam int WB  = bba_pkg::WORD_BITS;
    localparam int WW  = bba_pkg::WORD_W;
    localparam int BW  = bba_pkg::BLK_W;
    localparam int CW  = bba_pkg::CNT_W;
    localparam int LB  = bba_pkg::LANE_BITS;
    localparam int LW  = bba_pkg::LANE_W;
    localparam int LOW = bba_pkg::LANE_OFS_W;
    localparam int OW  = bba_pkg::OFS_W;

    // request and state registers
    bba_pkg::t_req      r_kind;
    logic [BW-1:0]      r_start;
    logic [BW-1:0]      r_count;
    logic [CW-1:0]      r_total;
    logic [CW-1:0]      r_cnt;
    logic [WW-1:0]      r_word;
    logic [LW-1:0]      r_lane;
    logic [CW-1:0]      r_run;
    bba_pkg::t_status   r_status;
    logic [BW-1:0]      r_found;
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [BW-1:0]      r_out_found;
    logic [CW-1:0]      r_out_free;

    logic [CW-1:0]      total_eff;
    logic [BW-1:0]      hi_blk;
    logic [WW-1:0]      lo_word;
    logic [WW-1:0]      hi_word;
    logic [WB-1:0]      mask_lo;
    logic [WB-1:0]      mask_hi;
    logic [WB-1:0]      mask;
    logic [WB-1:0]      rdata;
    logic [WB-1:0]      wdata;
    logic               we;
    logic [LB-1:0]      lane_bits;
    logic [CW-1:0]      lane_base;
    logic [CW-1:0]      v_run;
    logic               v_done;
    logic               v_stop;
    logic [BW-1:0]      v_found;
    logic [CW-1:0]      v_idx;
    logic [CW:0]        free_sum;
    logic [CW-1:0]      cnt_next;

    // effective total clamps at the bitmap size
    assign total_eff = (r_total > bba_pkg::CNT_RESET) ? bba_pkg::CNT_RESET : r_total;

    // range bounds and word masks
    assign hi_blk  = r_start + r_count - BW'(1);
    assign lo_word = r_start[BW-1:OW];
    assign hi_word = hi_blk[BW-1:OW];
    assign mask_lo = (r_word == lo_word) ? ({WB{1'b1}} << r_start[OW-1:0]) : {WB{1'b1}};
    assign mask_hi = (r_word == hi_word) ?
                     ({WB{1'b1}} >> (OW'(WB - 1) - hi_blk[OW-1:0])) : {WB{1'b1}};
    assign mask    = mask_lo & mask_hi;

    // bitmap memory, one word per entry
    assign we    = i_cmd.clr_write | i_cmd.map_write;
    assign wdata = i_cmd.clr_write ? '0 :
                   (r_kind == bba_pkg::REQ_ALLOC) ? (rdata | mask) : (rdata & ~mask);

    bba_ram #(
        .WIDTH (WB),
        .DEPTH (bba_pkg::NUM_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_addr  (r_word),
        .i_we    (we),
        .i_wdata (wdata),
        .i_re    (i_cmd.mem_read),
        .o_rdata (rdata)
    );

    // run scanner over one lane of the current word
    assign lane_bits = rdata[{r_lane, LOW'(0)} +: LB];
    assign lane_base = {1'b0, r_word, r_lane, LOW'(0)};

    always_comb begin
        v_run   = r_run;
        v_done  = 1'b0;
        v_stop  = 1'b0;
        v_found = '0;
        v_idx   = '0;
        for (int k = 0; k < LB; k++) begin
            v_idx = lane_base + CW'(k);
            if (!v_done && !v_stop) begin
                if (v_idx >= total_eff) begin
                    v_stop = 1'b1;
                end else if (!lane_bits[k]) begin
                    v_run = v_run + CW'(1);
                    if (v_run >= {1'b0, r_count}) begin
                        v_done  = 1'b1;
                        v_found = BW'(v_idx + CW'(1) - {1'b0, r_count});
                    end
                end else begin
                    v_run = '0;
                end
            end
        end
    end

    // free counter update, saturating both ways
    assign free_sum = {1'b0, r_cnt} + {2'b00, r_count};
    always_comb begin
        if (r_kind == bba_pkg::REQ_ALLOC) begin
            cnt_next = (r_cnt >= {1'b0, r_count}) ? (r_cnt - {1'b0, r_count}) : '0;
        end else begin
            cnt_next = free_sum[CW] ? bba_pkg::CNT_MAX : free_sum[CW-1:0];
        end
    end

    // status to the controller
    always_comb begin
        o_sts.kind       = r_kind;
        o_sts.count_zero = (r_count == '0);
        o_sts.range_past = (({1'b0, r_start} + {1'b0, r_count}) > total_eff);
        o_sts.clr_last   = (r_word == WW'(bba_pkg::NUM_WORDS - 1));
        o_sts.lane_found = v_done;
        o_sts.lane_end   = v_stop || ((lane_base + CW'(LB)) >= total_eff);
        o_sts.lane_last  = (r_lane == {LW{1'b1}});
        o_sts.word_hit   = |(rdata & mask);
        o_sts.last_word  = (r_word == hi_word);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= bba_pkg::CNT_RESET;
            r_cnt       <= bba_pkg::CNT_RESET;
            r_word      <= '0;
            r_lane      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_total;
            end
            if (i_cmd.cnt_update) begin
                r_cnt <= cnt_next;
            end
            if (i_cmd.scan_init) begin
                r_word <= (r_kind == bba_pkg::REQ_FIND) ? '0 : lo_word;
                r_lane <= '0;
            end else if (i_cmd.word_next) begin
                r_word <= r_word + WW'(1);
            end
            if (i_cmd.lane_step) begin
                r_lane <= r_lane + LW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request, scan and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_kind   <= bba_pkg::t_req'(i_req_type);
            r_start  <= i_range_start;
            r_count  <= i_block_count;
            r_status <= bba_pkg::ST_OK;
            r_found  <= '0;
        end
        if (i_cmd.status_load) begin
            r_status <= i_cmd.status_val;
        end
        if (i_cmd.scan_init) begin
            r_run <= '0;
        end else if (i_cmd.lane_step) begin
            r_run <= v_run;
            if (v_done) begin
                r_status <= bba_pkg::ST_OK;
                r_found  <= v_found;
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_free   <= r_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found     = r_out_found;
    assign o_free      = r_out_free;

endmodule

// ===== design/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// request sequencer: clearing pass, find scan, check and write passes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bba_pkg::t_sts  i_sts,
    output bba_pkg::t_cmd  o_cmd
);

    bba_pkg::t_state r_state;
    bba_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bba_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = bba_pkg::S_IDLE;
            end
            bba_pkg::S_IDLE: begin
                if (i_in_valid) n_state = bba_pkg::S_DECODE;
            end
            bba_pkg::S_DECODE: begin
                priority case (i_sts.kind)
                    bba_pkg::REQ_FIND: begin
                        n_state = i_sts.count_zero ? bba_pkg::S_RESP : bba_pkg::S_FIND_RD;
                    end
                    bba_pkg::REQ_ALLOC: begin
                        if (i_sts.range_past || i_sts.count_zero) n_state = bba_pkg::S_RESP;
                        else n_state = bba_pkg::S_CHK_RD;
                    end
                    bba_pkg::REQ_FREE: begin
                        if (i_sts.range_past || i_sts.count_zero) n_state = bba_pkg::S_RESP;
                        else n_state = bba_pkg::S_SET_RD;
                    end
                    default: n_state = bba_pkg::S_RESP;
                endcase
            end
            bba_pkg::S_FIND_RD: n_state = bba_pkg::S_FIND_LANE;
            bba_pkg::S_FIND_LANE: begin
                if (i_sts.lane_found || i_sts.lane_end) n_state = bba_pkg::S_RESP;
                else if (i_sts.lane_last) n_state = bba_pkg::S_FIND_RD;
            end
            bba_pkg::S_CHK_RD: n_state = bba_pkg::S_CHK_TEST;
            bba_pkg::S_CHK_TEST: begin
                if (i_sts.word_hit) n_state = bba_pkg::S_RESP;
                else if (i_sts.last_word) n_state = bba_pkg::S_SET_RD;
                else n_state = bba_pkg::S_CHK_RD;
            end
            bba_pkg::S_SET_RD: n_state = bba_pkg::S_SET_WR;
            bba_pkg::S_SET_WR: begin
                n_state = i_sts.last_word ? bba_pkg::S_RESP : bba_pkg::S_SET_RD;
            end
            bba_pkg::S_RESP: begin
                if (i_sts.out_free) n_state = bba_pkg::S_IDLE;
            end
            default: n_state = bba_pkg::S_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.status_val = bba_pkg::ST_OK;
        o_in_ready       = 1'b0;
        unique case (r_state)
            bba_pkg::S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                o_cmd.word_next = 1'b1;
            end
            bba_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.req_load = i_in_valid;
            end
            bba_pkg::S_DECODE: begin
                o_cmd.scan_init = 1'b1;
                if (i_sts.kind == bba_pkg::REQ_FIND && !i_sts.count_zero) begin
                    o_cmd.status_load = 1'b1;
                    o_cmd.status_val  = bba_pkg::ST_NOFREE;
                end else if ((i_sts.kind == bba_pkg::REQ_ALLOC ||
                              i_sts.kind == bba_pkg::REQ_FREE) && i_sts.range_past) begin
                    o_cmd.status_load = 1'b1;
                    o_cmd.status_val  = bba_pkg::ST_PAST;
                end
            end
            bba_pkg::S_FIND_RD: o_cmd.mem_read = 1'b1;
            bba_pkg::S_FIND_LANE: begin
                o_cmd.lane_step = 1'b1;
                o_cmd.word_next = i_sts.lane_last && !i_sts.lane_found && !i_sts.lane_end;
            end
            bba_pkg::S_CHK_RD: o_cmd.mem_read = 1'b1;
            bba_pkg::S_CHK_TEST: begin
                if (i_sts.word_hit) begin
                    o_cmd.status_load = 1'b1;
                    o_cmd.status_val  = bba_pkg::ST_USED;
                end else if (i_sts.last_word) begin
                    o_cmd.scan_init = 1'b1;
                end else begin
                    o_cmd.word_next = 1'b1;
                end
            end
            bba_pkg::S_SET_RD: o_cmd.mem_read = 1'b1;
            bba_pkg::S_SET_WR: begin
                o_cmd.map_write  = 1'b1;
                o_cmd.cnt_update = i_sts.last_word;
                o_cmd.word_next  = !i_sts.last_word;
            end
            bba_pkg::S_RESP: o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== design/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// first-fit block allocator over a one-bit-per-block bitmap
// ----------------------------------------------------------------------------
// The bitmap sits in a 2048 x 32 single-port ram. After reset a clearing pass
// writes every word to zero, during which no request is taken (configuration
// writes are accepted at all times). One request is handled at a time. Find
// reads a word and then scans it in four 8-bit lanes in turn, word after word.
// Allocate reads and tests every word its range touches, stopping at the first
// word with a used block, then reads and rewrites them. Free reads and rewrites
// each touched word. Refused and zero-length requests skip the bitmap passes.
// The result sits in an output register, so a new request is taken while the
// previous word still waits on the response side.
`timescale 1ns / 1ps

module bitmap_block_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bba_req_if.sink    i_req,
    bba_rsp_if.source  o_rsp,
    bba_cfg_if.sink    i_cfg
);

    bba_pkg::t_cmd cmd;
    bba_pkg::t_sts sts;

    // configuration register is always writable
    assign i_cfg.ready = 1'b1;

    // sequencer
    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // bitmap, counter and result path
    bba_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req.req_type),
        .i_range_start (i_req.range_start),
        .i_block_count (i_req.block_count),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_total   (i_cfg.usable_blocks),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_found       (o_rsp.found_start),
        .o_free        (o_rsp.free_blocks)
    );

endmodule

// ===== design/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_block_allocator_macros.svh"

module bba_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [1:0]                i_status,
    input logic [bba_pkg::BLK_W-1:0] i_found
);

    // a pending response word is not dropped
    `BBA_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "response dropped")

    // one request at a time: busy right after taking a word
    `BBA_ASSERT(a_busy_after_take, i_in_valid && i_in_ready |=> !i_in_ready, "took two requests")

    // only a successful find reports a start block
    `BBA_ASSERT(a_found_zero, i_out_valid && i_status != bba_pkg::ST_OK |-> i_found == '0, "start on failure")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_found     (o_rsp.found_start)
);
